FILE: rtl/lrc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrc_pkg
// shared constants of the line/rectangle clipper
// ----------------------------------------------------------------------------
package lrc_pkg;

	localparam int COLOR_W     = 32;
	localparam int WIN_H_RESET = 184320;

endpackage
`default_nettype wire

FILE: rtl/lrc_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrc_in_if / lrc_out_if
// valid/ready channels carrying one segment word and one clipped word
// ----------------------------------------------------------------------------
interface lrc_in_if #(parameter int CW = 24);
	import lrc_pkg::*;

	logic                  valid;
	logic                  ready;
	logic signed [CW-1:0]  start_x;
	logic signed [CW-1:0]  start_y;
	logic signed [CW-1:0]  end_x;
	logic signed [CW-1:0]  end_y;
	logic signed [CW-1:0]  box_left;
	logic signed [CW-1:0]  box_bottom;
	logic signed [CW-1:0]  box_right;
	logic signed [CW-1:0]  box_top;
	logic [COLOR_W-1:0]    line_color;

	modport source (output valid, start_x, start_y, end_x, end_y, box_left, box_bottom,
		box_right, box_top, line_color, input ready);
	modport sink (input valid, start_x, start_y, end_x, end_y, box_left, box_bottom,
		box_right, box_top, line_color, output ready);
endinterface

interface lrc_out_if #(parameter int CW = 24);
	import lrc_pkg::*;

	logic                  valid;
	logic                  ready;
	logic                  draw;
	logic signed [CW-1:0]  screen_x0;
	logic signed [CW-1:0]  screen_y0;
	logic signed [CW-1:0]  screen_x1;
	logic signed [CW-1:0]  screen_y1;
	logic [COLOR_W-1:0]    out_color;

	modport source (output valid, draw, screen_x0, screen_y0, screen_x1, screen_y1,
		out_color, input ready);
	modport sink (input valid, draw, screen_x0, screen_y0, screen_x1, screen_y1,
		out_color, output ready);
endinterface
`default_nettype wire

FILE: rtl/lrc_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrc_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module lrc_div #(
	parameter int DW = 24,
	parameter int PW = 48
) (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire logic [PW-1:0] dvd,
	input  wire logic [DW-1:0] dvs,
	output logic [PW-1:0]      quo,
	output logic [DW-1:0]      rem,
	output logic [DW-1:0]      dvs_out
);
	logic [DW-1:0] rem_s [PW];
	logic [PW-1:0] quo_s [PW];
	logic [DW-1:0] dvs_s [PW];

	for (genvar k = 0; k < PW; k++) begin : g_stage
		logic [DW-1:0] pr;
		logic [DW-1:0] pd;
		logic [PW-1:0] pq;
		logic [DW:0]   trial;
		logic          ge;

		if (k == 0) begin : g_first
			assign pr = '0;
			assign pq = dvd;
			assign pd = dvs;
		end else begin : g_next
			assign pr = rem_s[k-1];
			assign pq = quo_s[k-1];
			assign pd = dvs_s[k-1];
		end

		assign trial = {pr, pq[PW-1]};
		assign ge    = trial >= {1'b0, pd};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? DW'(trial - {1'b0, pd}) : trial[DW-1:0];
				quo_s[k] <= {pq[PW-2:0], ge};
				dvs_s[k] <= pd;
			end
		end
	end

	assign quo     = quo_s[PW-1];
	assign rem     = rem_s[PW-1];
	assign dvs_out = dvs_s[PW-1];
endmodule
`default_nettype wire

FILE: rtl/line_rect_clipper_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// line_rect_clipper_top
// clips a fixed point segment against a box and flips y to screen space
//
//   channel    dir  handshake        word
//   in_word    in   valid/ready      segment, box, color
//   out_word   out  valid/ready      draw flag, screen endpoints, color
//   cfg        in   cfg_we           window height
//
// one word per cycle while the output is not stalled; the four
// one-bit-per-stage intersection dividers run side by side
// arst_n clears all valid bits and loads the reset window height
// a stalled output freezes the whole pipe; in_word.ready drops only then
// ----------------------------------------------------------------------------
module line_rect_clipper_top #(
	parameter int COORD_WIDTH = 24
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [COORD_WIDTH-2:0] cfg_wdata,
	lrc_in_if.sink                      in_word,
	lrc_out_if.source                   out_word
);
	import lrc_pkg::*;

	localparam int CW = COORD_WIDTH;
	localparam int NW = CW + 1;
	localparam int MW = 2 * NW;
	localparam int PW = 2 * CW;
	localparam int SW = PW + 3;
	localparam logic [CW-2:0] WH_RST = (CW-1)'(WIN_H_RESET);
	localparam logic [CW-1:0] MINV = {1'b1, {(CW-1){1'b0}}};
	localparam logic [CW-1:0] MAXV = {1'b0, {(CW-1){1'b1}}};

	typedef struct packed {
		logic                 vld;
		logic                 xok;
		logic                 yok;
		logic [3:0]           neg;
		logic signed [CW-1:0] sx;
		logic signed [CW-1:0] sy;
		logic signed [CW-1:0] ex;
		logic signed [CW-1:0] ey;
		logic signed [CW-1:0] bl;
		logic signed [CW-1:0] bb;
		logic signed [CW-1:0] br;
		logic signed [CW-1:0] bt;
		logic [COLOR_W-1:0]   color;
	} side_t;

	function automatic logic [CW-1:0] sat_cw(input logic signed [SW-1:0] v);
		logic fits;
		fits = (&v[SW-1:CW-1]) | ~(|v[SW-1:CW-1]);
		return fits ? v[CW-1:0] : (v[SW-1] ? MINV : MAXV);
	endfunction

	logic en;
	logic out_vld_q;
	logic [CW-2:0] wh_q;

	assign en = !out_vld_q || out_word.ready;
	assign in_word.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wh_q <= WH_RST;
		end else if (cfg_we) begin
			wh_q <= cfg_wdata;
		end
	end

	// stage 1: deltas and edge offsets
	side_t side_in, side_s1, side_s2, side_s3;
	logic signed [NW-1:0] dx_s1, dy_s1;
	logic signed [NW-1:0] num_s1 [4];

	always_comb begin
		side_in.vld   = in_word.valid;
		side_in.xok   = in_word.end_x != in_word.start_x;
		side_in.yok   = in_word.end_y != in_word.start_y;
		side_in.neg   = '0;
		side_in.sx    = in_word.start_x;
		side_in.sy    = in_word.start_y;
		side_in.ex    = in_word.end_x;
		side_in.ey    = in_word.end_y;
		side_in.bl    = in_word.box_left;
		side_in.bb    = in_word.box_bottom;
		side_in.br    = in_word.box_right;
		side_in.bt    = in_word.box_top;
		side_in.color = in_word.line_color;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s1 <= '0;
		end else if (en) begin
			side_s1 <= side_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1     <= NW'(in_word.end_x) - NW'(in_word.start_x);
			dy_s1     <= NW'(in_word.end_y) - NW'(in_word.start_y);
			num_s1[0] <= NW'(in_word.box_left) - NW'(in_word.start_x);
			num_s1[1] <= NW'(in_word.box_right) - NW'(in_word.start_x);
			num_s1[2] <= NW'(in_word.box_bottom) - NW'(in_word.start_y);
			num_s1[3] <= NW'(in_word.box_top) - NW'(in_word.start_y);
		end
	end

	// stage 2: products
	logic signed [NW-1:0] dx_s2, dy_s2;
	logic signed [MW-1:0] prod_s2 [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s2 <= '0;
		end else if (en) begin
			side_s2 <= side_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s2      <= dx_s1;
			dy_s2      <= dy_s1;
			prod_s2[0] <= num_s1[0] * dy_s1;
			prod_s2[1] <= num_s1[1] * dy_s1;
			prod_s2[2] <= num_s1[2] * dx_s1;
			prod_s2[3] <= num_s1[3] * dx_s1;
		end
	end

	// stage 3: magnitudes and quotient signs
	logic [PW-1:0] mag_s3 [4];
	logic [CW-1:0] ud_s3 [4];
	logic [CW-1:0] udx, udy;
	side_t side_n2;

	assign udx = dx_s2[NW-1] ? CW'(-dx_s2) : CW'(dx_s2);
	assign udy = dy_s2[NW-1] ? CW'(-dy_s2) : CW'(dy_s2);

	// x-edge quotients divide by dx, y-edge quotients by dy
	always_comb begin
		side_n2     = side_s2;
		side_n2.neg = {prod_s2[3][MW-1] ^ dy_s2[NW-1], prod_s2[2][MW-1] ^ dy_s2[NW-1],
			prod_s2[1][MW-1] ^ dx_s2[NW-1], prod_s2[0][MW-1] ^ dx_s2[NW-1]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s3 <= '0;
		end else if (en) begin
			side_s3 <= side_n2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 4; j++) begin
				mag_s3[j] <= prod_s2[j][MW-1] ? PW'(-prod_s2[j]) : PW'(prod_s2[j]);
			end
			ud_s3[0] <= udx;
			ud_s3[1] <= udx;
			ud_s3[2] <= udy;
			ud_s3[3] <= udy;
		end
	end

	// dividers with a matching side line
	logic [PW-1:0] quo [4];
	logic [CW-1:0] rem [4];
	logic [CW-1:0] dvs [4];
	side_t side_d [PW];

	for (genvar j = 0; j < 4; j++) begin : g_div
		lrc_div #(
			.DW (CW),
			.PW (PW)
		) u_div (
			.clk     (clk),
			.en      (en),
			.dvd     (mag_s3[j]),
			.dvs     (ud_s3[j]),
			.quo     (quo[j]),
			.rem     (rem[j]),
			.dvs_out (dvs[j])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < PW; k++) begin
				side_d[k] <= '0;
			end
		end else if (en) begin
			side_d[0] <= side_s3;
			for (int k = 1; k < PW; k++) begin
				side_d[k] <= side_d[k-1];
			end
		end
	end

	// stage 4: round to nearest
	side_t side_s4, side_s5, side_s6, side_s7, side_s8;
	logic [PW:0] qr_s4 [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s4 <= '0;
			side_s5 <= '0;
			side_s6 <= '0;
			side_s7 <= '0;
			side_s8 <= '0;
		end else if (en) begin
			side_s4 <= side_d[PW-1];
			side_s5 <= side_s4;
			side_s6 <= side_s5;
			side_s7 <= side_s6;
			side_s8 <= side_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 4; j++) begin
				qr_s4[j] <= (PW+1)'(quo[j]) + (PW+1)'({rem[j], 1'b0} >= {1'b0, dvs[j]});
			end
		end
	end

	// stage 5: apply sign
	logic signed [PW+1:0] r_s5 [4];
	logic signed [PW+1:0] qmag [4];

	always_comb begin
		for (int j = 0; j < 4; j++) begin
			qmag[j] = {1'b0, qr_s4[j]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 4; j++) begin
				r_s5[j] <= side_s4.neg[j] ? -qmag[j] : qmag[j];
			end
		end
	end

	// stage 6: intersection coordinates
	logic signed [CW-1:0] isect_s6 [4];

	always_ff @(posedge clk) begin
		if (en) begin
			isect_s6[0] <= sat_cw(SW'(side_s5.sy) + SW'(r_s5[0]));
			isect_s6[1] <= sat_cw(SW'(side_s5.sy) + SW'(r_s5[1]));
			isect_s6[2] <= sat_cw(SW'(side_s5.sx) + SW'(r_s5[2]));
			isect_s6[3] <= sat_cw(SW'(side_s5.sx) + SW'(r_s5[3]));
		end
	end

	// stage 7: endpoint replacement
	logic signed [CW-1:0] px [2];
	logic signed [CW-1:0] py [2];
	logic signed [CW-1:0] x_s7 [2];
	logic signed [CW-1:0] y_s7 [2];

	always_comb begin
		px[0] = side_s6.sx;
		py[0] = side_s6.sy;
		px[1] = side_s6.ex;
		py[1] = side_s6.ey;
		for (int i = 0; i < 2; i++) begin
			if (side_s6.xok && px[i] < side_s6.bl) begin
				px[i] = side_s6.bl;
				py[i] = isect_s6[0];
			end
			if (side_s6.xok && px[i] > side_s6.br) begin
				px[i] = side_s6.br;
				py[i] = isect_s6[1];
			end
			if (side_s6.yok && py[i] < side_s6.bb) begin
				px[i] = isect_s6[2];
				py[i] = side_s6.bb;
			end
			if (side_s6.yok && py[i] > side_s6.bt) begin
				px[i] = isect_s6[3];
				py[i] = side_s6.bt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s7 <= px;
			y_s7 <= py;
		end
	end

	// stage 8: snap axis-aligned segments onto the box
	logic signed [CW-1:0] sxv [2];
	logic signed [CW-1:0] syv [2];
	logic signed [CW-1:0] x_s8 [2];
	logic signed [CW-1:0] y_s8 [2];

	always_comb begin
		sxv = x_s7;
		syv = y_s7;
		if (sxv[0] == sxv[1]) begin
			if (sxv[0] > side_s7.br) begin
				sxv[0] = side_s7.br;
				sxv[1] = side_s7.br;
			end
			if (sxv[0] < side_s7.bl) begin
				sxv[0] = side_s7.bl;
				sxv[1] = side_s7.bl;
			end
		end
		if (syv[0] == syv[1]) begin
			if (syv[0] > side_s7.bt) begin
				syv[0] = side_s7.bt;
				syv[1] = side_s7.bt;
			end
			if (syv[0] < side_s7.bb) begin
				syv[0] = side_s7.bb;
				syv[1] = side_s7.bb;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s8 <= sxv;
			y_s8 <= syv;
		end
	end

	// output register: y flip and draw flag
	logic signed [SW-1:0] wh_ext;
	logic                 draw_q;
	logic [CW-1:0]        x0_q, y0_q, x1_q, y1_q;
	logic [COLOR_W-1:0]   color_q;

	assign wh_ext = SW'($signed({1'b0, wh_q}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= side_s8.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			draw_q  <= !(x_s8[0] == x_s8[1] && y_s8[0] == y_s8[1]);
			x0_q    <= x_s8[0];
			x1_q    <= x_s8[1];
			y0_q    <= sat_cw(wh_ext - SW'(y_s8[0]));
			y1_q    <= sat_cw(wh_ext - SW'(y_s8[1]));
			color_q <= side_s8.color;
		end
	end

	assign out_word.valid     = out_vld_q;
	assign out_word.draw      = draw_q;
	assign out_word.screen_x0 = x0_q;
	assign out_word.screen_y0 = y0_q;
	assign out_word.screen_x1 = x1_q;
	assign out_word.screen_y1 = y1_q;
	assign out_word.out_color = color_q;
endmodule
`default_nettype wire

FILE: rtl/lrc_chk.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrc_chk
// port-level checks on the clipper, bound to the top level
// ----------------------------------------------------------------------------
module lrc_chk #(
	parameter int CW = 24
) (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          in_valid,
	input wire logic          in_ready,
	input wire logic          out_valid,
	input wire logic          out_ready,
	input wire logic          draw,
	input wire logic [CW-1:0] sx0,
	input wire logic [CW-1:0] sy0,
	input wire logic [CW-1:0] sx1,
	input wire logic [CW-1:0] sy1
);
	// input side only stalls behind a waiting output word
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("in ready does not follow output stall");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(sx0) && $stable(sy0)
			&& $stable(sx1) && $stable(sy1) && $stable(draw))
		else $error("stalled output word changed");

	a_nodraw: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !draw |-> sx0 == sx1 && sy0 == sy1)
		else $error("draw cleared on distinct endpoints");

	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |-> out_valid)
		else $error("input stalled with no output waiting");
endmodule

bind line_rect_clipper_top lrc_chk #(
	.CW (COORD_WIDTH)
) u_lrc_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_word.valid),
	.in_ready  (in_word.ready),
	.out_valid (out_word.valid),
	.out_ready (out_word.ready),
	.draw      (out_word.draw),
	.sx0       (out_word.screen_x0),
	.sy0       (out_word.screen_y0),
	.sx1       (out_word.screen_x1),
	.sy1       (out_word.screen_y1)
);
`default_nettype wire
